// ===== src/qsc_pkg.sv =====
// shared types and constants of the quad shape classifier
`timescale 1ns / 1ps
`default_nettype none
package qsc_pkg;

    localparam int CORDIC_STEPS = 20;
    localparam int TAB_FRAC = 16;

    localparam int QUEUE_DEPTH = 32;
    localparam int QPTR_BITS = 5;
    localparam int QCNT_BITS = 6;

    localparam int SHAPE_BITS = 2;
    localparam int TOL_BITS = 15;
    localparam int MINLEN_BITS = 14;
    localparam int PCT_BITS = 7;
    localparam int CFG_DATA_BITS = 15;
    localparam int CFG_ADDR_BITS = 2;

    localparam logic [SHAPE_BITS-1:0] SHAPE_SQUARE = 2'd0;
    localparam logic [SHAPE_BITS-1:0] SHAPE_RECT = 2'd1;
    localparam logic [SHAPE_BITS-1:0] SHAPE_QUAD = 2'd2;

    localparam logic [CFG_ADDR_BITS-1:0] REG_ANGLE_TOL = 2'd0;
    localparam logic [CFG_ADDR_BITS-1:0] REG_MIN_LEN = 2'd1;
    localparam logic [CFG_ADDR_BITS-1:0] REG_LEN_PCT = 2'd2;

    typedef struct packed {
        logic [TOL_BITS-1:0]    angle_tolerance;
        logic [MINLEN_BITS-1:0] min_length;
        logic [PCT_BITS-1:0]    length_tolerance_pct;
    } cfg_t;

    typedef struct packed {
        logic is_match;
        logic all_right_angles;
    } result_t;

    // arctangent of 2^-step in degrees, 16 fraction bits
    function automatic logic [23:0] atan_q16(input int step);
        logic [23:0] r;
        case (step)
            0:       r = 24'd2949120;
            1:       r = 24'd1740967;
            2:       r = 24'd919879;
            3:       r = 24'd466945;
            4:       r = 24'd234379;
            5:       r = 24'd117304;
            6:       r = 24'd58666;
            7:       r = 24'd29335;
            8:       r = 24'd14668;
            9:       r = 24'd7334;
            10:      r = 24'd3667;
            11:      r = 24'd1833;
            12:      r = 24'd917;
            13:      r = 24'd458;
            14:      r = 24'd229;
            15:      r = 24'd115;
            16:      r = 24'd57;
            17:      r = 24'd29;
            18:      r = 24'd14;
            19:      r = 24'd7;
            default: r = 24'd0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== src/qsc_cordic.sv =====
// pipelined vectoring cordic giving a direction in degrees
`timescale 1ns / 1ps
`default_nettype none
module qsc_cordic #(
    parameter int COORD_BITS = 13,
    parameter int ANGLE_FRAC_BITS = 8
) (
    input  wire logic                              clk,
    input  wire logic signed [COORD_BITS:0]        vec_a,
    input  wire logic signed [COORD_BITS:0]        vec_b,
    output logic signed [ANGLE_FRAC_BITS+9:0]      angle
);

    localparam int DW = COORD_BITS + 1;
    localparam int XW = COORD_BITS + 20;
    localparam int ZW = 26;
    localparam int STEPS = qsc_pkg::CORDIC_STEPS;
    localparam int TF = qsc_pkg::TAB_FRAC;
    localparam logic signed [ZW-1:0] Z_RIGHT = ZW'(90 << TF);
    localparam logic signed [ZW-1:0] Z_HALF_LSB = ZW'(1 << (TF - 1 - ANGLE_FRAC_BITS));

    logic signed [XW-1:0] x_reg [0:STEPS];
    logic signed [XW-1:0] y_reg [0:STEPS];
    logic signed [ZW-1:0] z_reg [0:STEPS];
    logic                 zero_reg [0:STEPS];

    logic signed [XW-1:0] xs;
    logic signed [XW-1:0] ys;
    logic signed [XW-1:0] x0;
    logic signed [XW-1:0] y0;
    logic signed [ZW-1:0] z0;
    logic signed [ZW-1:0] z_rnd;
    logic signed [ANGLE_FRAC_BITS+9:0] angle_reg;

    assign xs = {{(XW-DW-TF){vec_b[DW-1]}}, vec_b, {TF{1'b0}}};
    assign ys = {{(XW-DW-TF){vec_a[DW-1]}}, vec_a, {TF{1'b0}}};

    // left half plane: pre-rotate by a quarter turn
    always_comb
    begin
        x0 = xs;
        y0 = ys;
        z0 = '0;
        if (xs < 0)
        begin
            if (ys >= 0)
            begin
                x0 = ys;
                y0 = -xs;
                z0 = Z_RIGHT;
            end
            else
            begin
                x0 = -ys;
                y0 = xs;
                z0 = -Z_RIGHT;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg[0]    <= x0;
        y_reg[0]    <= y0;
        z_reg[0]    <= z0;
        zero_reg[0] <= (vec_a == '0) && (vec_b == '0);
    end

    for (genvar i = 0; i < STEPS; i++)
    begin : g_step
        localparam logic signed [ZW-1:0] ATAN = ZW'(qsc_pkg::atan_q16(i));
        always_ff @(posedge clk)
        begin
            zero_reg[i+1] <= zero_reg[i];
            if (y_reg[i] > 0)
            begin
                x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                z_reg[i+1] <= z_reg[i] + ATAN;
            end
            else
            begin
                x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                z_reg[i+1] <= z_reg[i] - ATAN;
            end
        end
    end

    // round half up to the output precision
    assign z_rnd = z_reg[STEPS] + Z_HALF_LSB;

    always_ff @(posedge clk)
    begin
        if (zero_reg[STEPS])
            angle_reg <= '0;
        else
            angle_reg <= z_rnd[ZW-1:TF-ANGLE_FRAC_BITS];
    end

    assign angle = angle_reg;

endmodule
`default_nettype wire

// ===== src/qsc_sqrt.sv =====
// pipelined distance: squares, then one root bit per stage
`timescale 1ns / 1ps
`default_nettype none
module qsc_sqrt #(
    parameter int COORD_BITS = 13
) (
    input  wire logic                        clk,
    input  wire logic signed [COORD_BITS:0]  diff_x,
    input  wire logic signed [COORD_BITS:0]  diff_y,
    output logic [COORD_BITS+4:0]            length
);

    localparam int DW = COORD_BITS + 1;
    localparam int RB = COORD_BITS + 5;
    localparam int VW = 2 * RB;

    logic signed [2*DW-1:0] sq_x;
    logic signed [2*DW-1:0] sq_y;
    logic [2*COORD_BITS:0]  d2_next;

    logic [RB:0]   rem_reg  [0:RB];
    logic [RB-1:0] root_reg [0:RB];
    logic [VW-1:0] rest_reg [0:RB];

    logic [RB+2:0] cur   [0:RB-1];
    logic [RB+2:0] trial [0:RB-1];
    logic [RB+2:0] diff  [0:RB-1];

    assign sq_x = diff_x * diff_x;
    assign sq_y = diff_y * diff_y;
    assign d2_next = {1'b0, sq_x[2*COORD_BITS-1:0]} + {1'b0, sq_y[2*COORD_BITS-1:0]};

    // value scaled by 256 so the root carries 4 fraction bits
    always_ff @(posedge clk)
    begin
        rem_reg[0]  <= '0;
        root_reg[0] <= '0;
        rest_reg[0] <= {1'b0, d2_next, 8'b0};
    end

    for (genvar j = 0; j < RB; j++)
    begin : g_bit
        assign cur[j]   = {rem_reg[j], rest_reg[j][VW-1 -: 2]};
        assign trial[j] = {1'b0, root_reg[j], 2'b01};
        assign diff[j]  = cur[j] - trial[j];

        always_ff @(posedge clk)
        begin
            rest_reg[j+1] <= {rest_reg[j][VW-3:0], 2'b00};
            if (cur[j] >= trial[j])
            begin
                rem_reg[j+1]  <= diff[j][RB:0];
                root_reg[j+1] <= {root_reg[j][RB-2:0], 1'b1};
            end
            else
            begin
                rem_reg[j+1]  <= cur[j][RB:0];
                root_reg[j+1] <= {root_reg[j][RB-2:0], 1'b0};
            end
        end
    end

    assign length = root_reg[RB];

endmodule
`default_nettype wire

// ===== src/qsc_front.sv =====
// front pipeline: corner angles, lengths, sort and shape decision
`timescale 1ns / 1ps
`default_nettype none
module qsc_front #(
    parameter int COORD_BITS = 13,
    parameter int ANGLE_FRAC_BITS = 8
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   in_valid,
    input  wire logic [qsc_pkg::SHAPE_BITS-1:0]         in_shape,
    input  wire logic [COORD_BITS-1:0]                  in_x [4],
    input  wire logic [COORD_BITS-1:0]                  in_y [4],
    input  wire qsc_pkg::cfg_t                          cfg,
    output logic                                        out_valid,
    output qsc_pkg::result_t                            out_result
);

    localparam int DW = COORD_BITS + 1;
    localparam int RB = COORD_BITS + 5;
    localparam int AW = ANGLE_FRAC_BITS + 10;
    localparam int CW = AW + 10;
    localparam int PW = RB + 7;
    localparam int LANG = qsc_pkg::CORDIC_STEPS + 3;
    localparam int LLEN = RB + 7;
    localparam int LMAX = (LANG > LLEN) ? LANG : LLEN;
    localparam int DA = LMAX - LANG;
    localparam int DL = LMAX - LLEN;
    localparam int PA [6] = '{0, 1, 2, 3, 3, 2};
    localparam int PB [6] = '{1, 2, 3, 0, 1, 0};
    localparam logic signed [AW:0] HALF_TURN = (AW+1)'(180 << ANGLE_FRAC_BITS);
    localparam logic signed [CW-1:0] RIGHT_SC = CW'(90 << (ANGLE_FRAC_BITS + 8));

    // input stage
    logic                               v0_reg;
    logic [qsc_pkg::SHAPE_BITS-1:0]     shape_reg;
    logic [COORD_BITS-1:0]              x_reg [4];
    logic [COORD_BITS-1:0]              y_reg [4];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v0_reg <= 1'b0;
        else
            v0_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        shape_reg <= in_shape;
        x_reg     <= in_x;
        y_reg     <= in_y;
    end

    // angle path
    logic signed [AW-1:0] ang1 [4];
    logic signed [AW-1:0] ang2 [4];

    for (genvar k = 0; k < 4; k++)
    begin : g_corner
        localparam int P = k;
        localparam int V = (k + 1) % 4;
        localparam int Q = (k + 2) % 4;
        logic signed [DW-1:0] dxp;
        logic signed [DW-1:0] dyp;
        logic signed [DW-1:0] dxq;
        logic signed [DW-1:0] dyq;

        assign dxp = $signed({1'b0, x_reg[P]}) - $signed({1'b0, x_reg[V]});
        assign dyp = $signed({1'b0, y_reg[P]}) - $signed({1'b0, y_reg[V]});
        assign dxq = $signed({1'b0, x_reg[Q]}) - $signed({1'b0, x_reg[V]});
        assign dyq = $signed({1'b0, y_reg[Q]}) - $signed({1'b0, y_reg[V]});

        qsc_cordic #(
            .COORD_BITS      (COORD_BITS),
            .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
        ) u_dir_prev (
            .clk   (clk),
            .vec_a (dxp),
            .vec_b (dyp),
            .angle (ang1[k])
        );

        qsc_cordic #(
            .COORD_BITS      (COORD_BITS),
            .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
        ) u_dir_next (
            .clk   (clk),
            .vec_a (dxq),
            .vec_b (dyq),
            .angle (ang2[k])
        );
    end

    logic [3:0]            corner_ok;
    logic                  straight_reg;
    logic signed [CW-1:0]  tol_sc;

    assign tol_sc = CW'(cfg.angle_tolerance) <<< ANGLE_FRAC_BITS;

    always_comb
    begin
        logic signed [AW:0]   d;
        logic [AW:0]          d_abs;
        logic signed [CW-1:0] lhs;
        for (int k = 0; k < 4; k++)
        begin
            d = (AW+1)'(ang2[k]) - (AW+1)'(ang1[k]);
            if (d > HALF_TURN)
                d = d - HALF_TURN;
            else if (d < -HALF_TURN)
                d = d + HALF_TURN;
            d_abs = (d < 0) ? unsigned'(-d) : unsigned'(d);
            lhs = $signed(CW'({d_abs, 8'b0}));
            corner_ok[k] = (lhs <= RIGHT_SC + tol_sc) && (lhs >= RIGHT_SC - tol_sc);
        end
    end

    always_ff @(posedge clk)
    begin
        straight_reg <= &corner_ok;
    end

    // length path
    logic [5:0][RB-1:0] len_w;

    for (genvar m = 0; m < 6; m++)
    begin : g_len
        logic signed [DW-1:0] ldx;
        logic signed [DW-1:0] ldy;

        assign ldx = $signed({1'b0, x_reg[PB[m]]}) - $signed({1'b0, x_reg[PA[m]]});
        assign ldy = $signed({1'b0, y_reg[PB[m]]}) - $signed({1'b0, y_reg[PA[m]]});

        qsc_sqrt #(
            .COORD_BITS (COORD_BITS)
        ) u_len (
            .clk    (clk),
            .diff_x (ldx),
            .diff_y (ldy),
            .length (len_w[m])
        );
    end

    // odd-even transposition sort, largest first, two passes a stage
    function automatic logic [5:0][RB-1:0] two_passes(input logic [5:0][RB-1:0] a);
        logic [5:0][RB-1:0] t;
        logic [RB-1:0]      s;
        t = a;
        for (int i = 0; i < 6; i += 2)
        begin
            if (t[i] < t[i+1])
            begin
                s = t[i];
                t[i] = t[i+1];
                t[i+1] = s;
            end
        end
        for (int i = 1; i < 5; i += 2)
        begin
            if (t[i] < t[i+1])
            begin
                s = t[i];
                t[i] = t[i+1];
                t[i+1] = s;
            end
        end
        return t;
    endfunction

    logic [5:0][RB-1:0] srt1_reg;
    logic [5:0][RB-1:0] srt2_reg;
    logic [5:0][RB-1:0] srt3_reg;

    always_ff @(posedge clk)
    begin
        srt1_reg <= two_passes(len_w);
        srt2_reg <= two_passes(srt1_reg);
        srt3_reg <= two_passes(srt2_reg);
    end

    // square test on the sorted lengths
    logic          min1_reg;
    logic          nz1_reg;
    logic [RB-1:0] d32_reg;
    logic [RB-1:0] d43_reg;
    logic [RB-1:0] l2_reg;
    logic [RB-1:0] l4_reg;
    logic          min2_reg;
    logic          nz2_reg;
    logic [PW-1:0] m1_reg;
    logic [PW-1:0] m2_reg;
    logic [PW-1:0] m3_reg;
    logic [PW-1:0] m4_reg;
    logic          min3_reg;
    logic          sq3_reg;

    always_ff @(posedge clk)
    begin
        min1_reg <= (RB+18)'(srt3_reg[5]) > (RB+18)'({cfg.min_length, 4'b0});
        nz1_reg  <= (srt3_reg[2] != '0) && (srt3_reg[4] != '0);
        d32_reg  <= (srt3_reg[3] > srt3_reg[2]) ? srt3_reg[3] - srt3_reg[2]
                                                : srt3_reg[2] - srt3_reg[3];
        d43_reg  <= (srt3_reg[4] > srt3_reg[3]) ? srt3_reg[4] - srt3_reg[3]
                                                : srt3_reg[3] - srt3_reg[4];
        l2_reg   <= srt3_reg[2];
        l4_reg   <= srt3_reg[4];

        min2_reg <= min1_reg;
        nz2_reg  <= nz1_reg;
        m1_reg   <= PW'(d32_reg) * PW'(7'd100);
        m2_reg   <= PW'(cfg.length_tolerance_pct) * PW'(l2_reg);
        m3_reg   <= PW'(d43_reg) * PW'(7'd100);
        m4_reg   <= PW'(cfg.length_tolerance_pct) * PW'(l4_reg);

        min3_reg <= min2_reg;
        sq3_reg  <= nz2_reg && (m1_reg < m2_reg) && (m3_reg < m4_reg);
    end

    // align both paths
    logic straight_al;
    logic min_al;
    logic sq_al;

    if (DA > 0)
    begin : g_adly
        logic [DA-1:0] dl;
        always_ff @(posedge clk)
        begin
            dl <= DA'({dl, straight_reg});
        end
        assign straight_al = dl[DA-1];
    end
    else
    begin : g_anodly
        assign straight_al = straight_reg;
    end

    if (DL > 0)
    begin : g_ldly
        logic [2*DL-1:0] dl;
        always_ff @(posedge clk)
        begin
            dl <= (2*DL)'({dl, sq3_reg, min3_reg});
        end
        assign sq_al  = dl[2*DL-1];
        assign min_al = dl[2*DL-2];
    end
    else
    begin : g_lnodly
        assign sq_al  = sq3_reg;
        assign min_al = min3_reg;
    end

    logic [LMAX*qsc_pkg::SHAPE_BITS-1:0] shape_dl;
    logic [LMAX-1:0]                     valid_dl;

    always_ff @(posedge clk)
    begin
        shape_dl <= (LMAX*qsc_pkg::SHAPE_BITS)'({shape_dl, shape_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_dl <= '0;
        else
            valid_dl <= LMAX'({valid_dl, v0_reg});
    end

    logic [qsc_pkg::SHAPE_BITS-1:0] shape_al;
    assign shape_al = shape_dl[LMAX*qsc_pkg::SHAPE_BITS-1 -: qsc_pkg::SHAPE_BITS];

    // decision
    logic             out_valid_reg;
    qsc_pkg::result_t result_reg;
    logic             match;

    always_comb
    begin
        match = 1'b0;
        if (min_al)
        begin
            if (straight_al && shape_al == qsc_pkg::SHAPE_SQUARE)
                match = sq_al;
            else if (straight_al && shape_al == qsc_pkg::SHAPE_RECT)
                match = 1'b1;
            else if (shape_al == qsc_pkg::SHAPE_QUAD)
                match = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= valid_dl[LMAX-1];
    end

    always_ff @(posedge clk)
    begin
        result_reg.is_match         <= match;
        result_reg.all_right_angles <= straight_al;
    end

    assign out_valid  = out_valid_reg;
    assign out_result = result_reg;

endmodule
`default_nettype wire

// ===== src/qsc_queue.sv =====
// result queue between the front pipeline and the consumer
`timescale 1ns / 1ps
`default_nettype none
module qsc_queue (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_en,
    input  wire qsc_pkg::result_t wr_data,
    input  wire logic             rd_en,
    output qsc_pkg::result_t      rd_data,
    output logic                  empty
);

    qsc_pkg::result_t                mem [qsc_pkg::QUEUE_DEPTH];
    logic [qsc_pkg::QPTR_BITS-1:0]   wr_ptr_reg;
    logic [qsc_pkg::QPTR_BITS-1:0]   rd_ptr_reg;
    logic [qsc_pkg::QCNT_BITS-1:0]   count_reg;
    logic [qsc_pkg::QCNT_BITS-1:0]   count_next;
    logic                            do_rd;

    assign do_rd = rd_en && (count_reg != '0);
    assign count_next = count_reg + qsc_pkg::QCNT_BITS'(wr_en)
                        - qsc_pkg::QCNT_BITS'(do_rd);

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_rd)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    assign rd_data = mem[rd_ptr_reg];
    assign empty   = (count_reg == '0);

endmodule
`default_nettype wire

// ===== src/quad_shape_classifier_unit.sv =====
// top level of the quad shape classifier
`timescale 1ns / 1ps
`default_nettype none
// path: an accepted transaction goes through the input registers, the front
//   pipeline and its output register into the result queue
// throughput: one transaction per cycle while full is low; the 32-entry result queue
//   also bounds the transactions in flight through the front pipeline
// reset: rst_n clears the pipeline valids, the queue and the credit count,
//   and loads angle_tolerance 2560, min_length 10, length_tolerance_pct 10
module quad_shape_classifier_unit #(
    parameter int COORD_BITS = 13,
    parameter int ANGLE_FRAC_BITS = 8
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    // input queue side
    input  wire logic                                 push,
    output logic                                      full,
    input  wire logic [qsc_pkg::SHAPE_BITS-1:0]       required_shape,
    input  wire logic [COORD_BITS-1:0]                corner0_x,
    input  wire logic [COORD_BITS-1:0]                corner0_y,
    input  wire logic [COORD_BITS-1:0]                corner1_x,
    input  wire logic [COORD_BITS-1:0]                corner1_y,
    input  wire logic [COORD_BITS-1:0]                corner2_x,
    input  wire logic [COORD_BITS-1:0]                corner2_y,
    input  wire logic [COORD_BITS-1:0]                corner3_x,
    input  wire logic [COORD_BITS-1:0]                corner3_y,
    // result queue side
    output logic                                      empty,
    input  wire logic                                 pop,
    output logic                                      is_match,
    output logic                                      all_right_angles,
    // configuration writes
    input  wire logic                                 cfg_we,
    input  wire logic [qsc_pkg::CFG_ADDR_BITS-1:0]    cfg_addr,
    input  wire logic [qsc_pkg::CFG_DATA_BITS-1:0]    cfg_wdata
);

    // configuration registers
    qsc_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.angle_tolerance      <= qsc_pkg::TOL_BITS'(2560);
            cfg_reg.min_length           <= qsc_pkg::MINLEN_BITS'(10);
            cfg_reg.length_tolerance_pct <= qsc_pkg::PCT_BITS'(10);
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                qsc_pkg::REG_ANGLE_TOL:
                    cfg_reg.angle_tolerance <= cfg_wdata[qsc_pkg::TOL_BITS-1:0];
                qsc_pkg::REG_MIN_LEN:
                    cfg_reg.min_length <= cfg_wdata[qsc_pkg::MINLEN_BITS-1:0];
                qsc_pkg::REG_LEN_PCT:
                    cfg_reg.length_tolerance_pct <= cfg_wdata[qsc_pkg::PCT_BITS-1:0];
                default:
                    ;
            endcase
        end
    end

    // handshakes
    logic push_acc;
    logic pop_acc;

    assign push_acc = push && !full;
    assign pop_acc  = pop && !empty;

    // credit count: transactions in the pipeline plus results in the queue,
    // so the queue can never overflow and the pipeline never stalls
    logic [qsc_pkg::QCNT_BITS-1:0] credit_reg;
    logic [qsc_pkg::QCNT_BITS-1:0] credit_next;

    assign credit_next = credit_reg + qsc_pkg::QCNT_BITS'(push_acc)
                         - qsc_pkg::QCNT_BITS'(pop_acc);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            credit_reg <= '0;
        else
            credit_reg <= credit_next;
    end

    assign full = (credit_reg == qsc_pkg::QCNT_BITS'(qsc_pkg::QUEUE_DEPTH));

    // front pipeline
    logic [COORD_BITS-1:0] px [4];
    logic [COORD_BITS-1:0] py [4];

    assign px[0] = corner0_x;
    assign py[0] = corner0_y;
    assign px[1] = corner1_x;
    assign py[1] = corner1_y;
    assign px[2] = corner2_x;
    assign py[2] = corner2_y;
    assign px[3] = corner3_x;
    assign py[3] = corner3_y;

    logic             res_valid;
    qsc_pkg::result_t res;
    qsc_pkg::result_t head;

    qsc_front #(
        .COORD_BITS      (COORD_BITS),
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (push_acc),
        .in_shape   (required_shape),
        .in_x       (px),
        .in_y       (py),
        .cfg        (cfg_reg),
        .out_valid  (res_valid),
        .out_result (res)
    );

    // back end: result queue toward the consumer
    qsc_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_valid),
        .wr_data (res),
        .rd_en   (pop),
        .rd_data (head),
        .empty   (empty)
    );

    assign is_match         = head.is_match;
    assign all_right_angles = head.all_right_angles;

endmodule
`default_nettype wire
